/* design/lru_key_tracker_unit_assert.svh */
// assertion helpers used by the tracker unit
`ifndef LRU_KEY_TRACKER_UNIT_ASSERT_SVH
`define LRU_KEY_TRACKER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LKT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lkt_pkg.sv */
package lkt_pkg;

  // fixed field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_W = 5;

  // default depth of the key chain
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried in the input tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_UPD
  } lkt_state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             upd_en;
    logic             hit;
    logic             insert;
    logic [KEY_W-1:0] key;
  } lkt_ctrl_t;

endpackage

/* design/lru_key_tracker_unit.sv */
// channel   | dir | handshake                      | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata: key, tuser: mode
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: key_echo, tuser: hit
// cfg       | in  | cfg_valid_i / cfg_ready_o      | cfg_data_i: capacity
//
// each item goes through four steps: accept, compare in every cell, encode the hit
// position, then shift the chain and load the output register.
// the update waits while the output register still holds an untaken result;
// a new item is accepted while a finished result waits.
// reset clears occupancy and restores capacity to 16; keys need no clearing.
`include "lru_key_tracker_unit_assert.svh"

module lru_key_tracker_unit import lkt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [KEY_W-1:0] s_axis_tdata,   // [31:0] key
  input  logic             s_axis_tuser,   // [0] mode
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [KEY_W-1:0] m_axis_tdata,   // [31:0] key_echo
  output logic             m_axis_tuser,   // [0] hit
  // capacity register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [EW-1:0] MAX_E = EW'(MAX_ENTRIES);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  lkt_state_e state_q, state_d;

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    occ_q, occ_d;
  logic [KEY_W-1:0] key_q;
  logic             mode_q;
  logic [IW-1:0]    pos_q, pos_d;
  logic             hit_q, hit_d;

  logic             m_valid_q, m_valid_d;
  logic [KEY_W-1:0] m_data_q;
  logic             m_user_q;

  logic [CW-1:0]    eff_cap, present, limit;
  logic [EW-1:0]    cap_x;
  logic             out_free, upd_go, accept;

  logic [MAX_ENTRIES-1:0]            match;
  logic [MAX_ENTRIES-1:0][KEY_W-1:0] cell_key;
  lkt_ctrl_t                         ctrl;

  // effective capacity and present window
  assign cap_x = EW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = ONE_C;
    end else if (cap_x > MAX_E) begin
      eff_cap = MAX_C;
    end else begin
      eff_cap = cap_x[CW-1:0];
    end
    present = (occ_q < eff_cap) ? occ_q : eff_cap;
    limit   = (present == eff_cap) ? eff_cap : present + ONE_C;
  end

  // capacity register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // sequencer
  assign out_free = !m_valid_q || m_axis_tready;
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    upd_go        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_SEL;
      end
      ST_SEL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          upd_go  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= s_axis_tdata;
      mode_q <= s_axis_tuser;
    end
  end

  // hit detect and position encode over the match flags
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        pos_d = pos_d | IW'(i);
      end
    end
    hit_d = |match;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      pos_q <= pos_d;
      hit_q <= hit_d;
    end
  end

  // an insert that misses sets occupancy to one past the present window, capped at the capacity
  always_comb begin
    occ_d = occ_q;
    if (upd_go && !hit_q && (mode_q == MODE_INSERT)) begin
      occ_d = limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // broadcast to the cells
  assign ctrl.cmp_en = (state_q == ST_CMP);
  assign ctrl.upd_en = upd_go;
  assign ctrl.hit    = hit_q;
  assign ctrl.insert = (mode_q == MODE_INSERT);
  assign ctrl.key    = key_q;

  // chain of key cells, most recent first
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    if (g == 0) begin : g_head
      assign prev_key = key_q;
    end else begin : g_body
      assign prev_key = cell_key[g-1];
    end
    lkt_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .present_i  (present),
      .limit_i    (limit),
      .pos_i      (pos_q),
      .key_prev_i (prev_key),
      .key_o      (cell_key[g]),
      .match_o    (match[g])
    );
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (upd_go) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      m_data_q <= key_q;
      m_user_q <= hit_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // checks
  `LKT_ASSERT_NEXT(a_accept_starts_cmp, accept, state_q == ST_CMP,
                   "accepted item did not start a compare")
  `LKT_ASSERT_SAME(a_occ_bound, 1'b1, occ_q <= MAX_C,
                   "occupancy beyond chain depth")
  `LKT_ASSERT_SAME(a_match_unique, state_q == ST_SEL, $onehot0(match),
                   "key matched in more than one present cell")
  `LKT_ASSERT_NEXT(a_result_from_upd, (state_q != ST_UPD) && !m_valid_q, !m_valid_q,
                   "result appeared outside the update step")

endmodule

/* design/lkt_cell.sv */
module lkt_cell import lkt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lkt_ctrl_t        ctrl_i,
  input  logic [CW-1:0]    present_i,
  input  logic [CW-1:0]    limit_i,
  input  logic [IW-1:0]    pos_i,
  input  logic [KEY_W-1:0] key_prev_i,
  output logic [KEY_W-1:0] key_o,
  output logic             match_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_P = IW'(IDX);

  logic [KEY_W-1:0] key_q;
  logic             match_q, match_d;
  logic             shift_en;

  // compare against the looked-up key, only inside the present window
  assign match_d = (IDX_C < present_i) && (key_q == ctrl_i.key);

  // take the neighbor's key when the front part of the chain moves down
  always_comb begin
    if (ctrl_i.hit) begin
      shift_en = ctrl_i.upd_en && (IDX_P <= pos_i);
    end else begin
      shift_en = ctrl_i.upd_en && ctrl_i.insert && (IDX_C < limit_i);
    end
  end

  // match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= match_d;
    end
  end

  // stored key
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      key_q <= key_prev_i;
    end
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule

/* tb/lru_key_tracker_unit_test.sv */
`timescale 1ns / 1ps

module lru_key_tracker_unit_test import lkt_pkg::*;;

  // one expected lookup outcome
  typedef struct {
    logic             hit;
    logic [KEY_W-1:0] key;
  } lookup_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [KEY_W-1:0] s_axis_tdata = '0;  // [31:0] key
  logic             s_axis_tuser = 1'b0;  // [0] mode
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [KEY_W-1:0] m_axis_tdata;  // [31:0] key_echo
  logic             m_axis_tuser;  // [0] hit
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i = '0;

  // predicted tracker state
  logic [KEY_W-1:0] lru_keys [MAX_ENTRIES_DEF];
  int unsigned      lru_fill;
  logic [CAP_W-1:0] lru_cap;

  lookup_result_t   pending_lookups [$];
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;
  int unsigned      error_count;
  int unsigned      mismatch_prints;
  int unsigned      items_sent;
  int unsigned      hits_seen;
  int unsigned      misses_seen;
  int unsigned      cap_writes;

  lru_key_tracker_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // capacity as the tracker uses it: zero means one, saturates at the depth
  function automatic int unsigned lru_cap_eff();
    if (lru_cap == 0) return 1;
    if (lru_cap > MAX_ENTRIES_DEF) return MAX_ENTRIES_DEF;
    return 32'(lru_cap);
  endfunction

  // look up a key, update the recency order, return the hit flag
  function automatic logic lru_access(input logic mode, input logic [KEY_W-1:0] key);
    int unsigned cap_eff;
    int unsigned live;
    int unsigned pos;
    int          i;
    logic        found;
    cap_eff = lru_cap_eff();
    live    = (lru_fill < cap_eff) ? lru_fill : cap_eff;
    found   = 1'b0;
    pos     = 0;
    for (i = 0; i < live; i++) begin
      if (!found && lru_keys[i] == key) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (!found && mode == MODE_INSERT) begin
      // new key goes in front, whatever lies past the capacity drops out
      pos      = (live + 1 > cap_eff) ? cap_eff - 1 : live;
      lru_fill = pos + 1;
    end
    if (found || mode == MODE_INSERT) begin
      for (i = pos; i > 0; i--) lru_keys[i] = lru_keys[i-1];
      lru_keys[0] = key;
    end
    return found;
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin : result_check
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_lookups.size() == 0) begin
        error_count++;
        $display("%0t unexpected item: key %h hit %0b", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_lookups.pop_front();
        if (m_axis_tuser) hits_seen++;
        else misses_seen++;
        if (m_axis_tuser !== want.hit) begin
          error_count++;
          if (mismatch_prints < 20)
            $display("%0t hit mismatch for key %h: expected %0b actual %0b",
                     $time, want.key, want.hit, m_axis_tuser);
          mismatch_prints++;
        end
        if (m_axis_tdata !== want.key) begin
          error_count++;
          if (mismatch_prints < 20)
            $display("%0t key_echo mismatch: expected %h actual %h",
                     $time, want.key, m_axis_tdata);
          mismatch_prints++;
        end
      end
    end
  end

  // send one lookup or insert, predicting its outcome on acceptance
  task automatic send_item(input logic mode, input logic [KEY_W-1:0] key);
    lookup_result_t want;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    want.hit = lru_access(mode, key);
    want.key = key;
    pending_lookups.push_back(want);
    items_sent++;
  endtask

  // stop sending and let every predicted item come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
  endtask

  // capacity is only written while the tracker is idle
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    lru_cap = value;
    cap_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  // extreme keys, hits, misses and move to front at reset capacity
  task automatic test_insert_read_extremes();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_item(MODE_INSERT, 32'h7fff_ffff);
    send_item(MODE_INSERT, 32'h8000_0000);
    send_item(MODE_INSERT, 32'h0000_0000);
    send_item(MODE_INSERT, 32'hffff_ffff);
    send_item(MODE_READ,   32'h8000_0000);
    send_item(MODE_READ,   32'h0001_2345);
    send_item(MODE_INSERT, 32'h0000_0000);
    send_item(MODE_READ,   32'hffff_ffff);
  endtask

  // shrinking, saturating and zero capacity
  task automatic test_capacity_limits();
    // entries past a lowered capacity are absent
    write_capacity(5'd2);
    send_item(MODE_READ, 32'h7fff_ffff);
    // and come back when it is raised, saturating above the depth
    write_capacity(5'd31);
    send_item(MODE_READ, 32'h7fff_ffff);
    // an insert under a low capacity discards the hidden ones for good
    write_capacity(5'd2);
    send_item(MODE_INSERT, 32'h0000_0005);
    write_capacity(5'd17);
    send_item(MODE_READ, 32'h0000_0000);
    send_item(MODE_READ, 32'h7fff_ffff);
    // zero capacity behaves as one entry
    write_capacity(5'd0);
    send_item(MODE_INSERT, 32'h0000_0009);
    send_item(MODE_INSERT, 32'h0000_000a);
    send_item(MODE_READ,   32'h0000_0009);
    send_item(MODE_READ,   32'h0000_000a);
    write_capacity(5'd1);
    send_item(MODE_INSERT, 32'h5555_5555);
    send_item(MODE_READ,   32'h0000_000a);
    send_item(MODE_READ,   32'h5555_5555);
  endtask

  // random traffic over a small key set per capacity, under every idle pattern
  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [8];
    logic [KEY_W-1:0] key_set [$];
    logic [KEY_W-1:0] key;
    int unsigned      set_size;
    int               ph;
    int               n;
    caps = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd8, 5'd0, 5'd17, 5'd2};
    caps[7] = CAP_W'($urandom_range(2, 15));
    for (ph = 0; ph < 8; ph++) begin
      write_capacity(caps[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 25; sink_stall_pct = 25; end
      endcase
      // a few more keys than fit, so both hits and evictions happen
      key_set.delete();
      set_size = lru_cap_eff() + $urandom_range(1, 6);
      for (n = 0; n < set_size; n++) begin
        key_set.push_back($urandom_range(3) == 0 ? $urandom_range(31) : $urandom());
      end
      for (n = 0; n < 200; n++) begin
        if ($urandom_range(99) < 85) key = key_set[$urandom_range(set_size - 1)];
        else key = $urandom();
        send_item($urandom_range(1) ? MODE_READ : MODE_INSERT, key);
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // test sequence
  initial begin
    for (int i = 0; i < MAX_ENTRIES_DEF; i++) lru_keys[i] = '0;
    lru_fill       = 0;
    lru_cap        = CAP_RESET;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_insert_read_extremes();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    repeat (12) @(posedge clk_i);
    $display("run covered %0d items (%0d hits, %0d misses) over %0d capacity writes",
             items_sent, hits_seen, misses_seen, cap_writes);
    $display("capacities from zero to saturation, with sender gaps and receiver stalls");
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d items outstanding", pending_lookups.size());
    $display("Verification failed");
    $finish;
  end

endmodule

/* lru_key_tracker_unit.f */
+incdir+design
design/lkt_pkg.sv
design/lkt_cell.sv
design/lru_key_tracker_unit.sv
tb/lru_key_tracker_unit_test.sv
